[design/dtcpq_pkg.sv]
package dtcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 31;
    localparam int SET_DEPTH   = 2 * QUEUE_DEPTH;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_BITS   = $clog2(SET_DEPTH);
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_SERVED_URGENT = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_SERVED_NORMAL = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY         = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL          = 3'd5;

    localparam int CMD_SERVE_BIT  = 1;
    localparam int CMD_URGENT_BIT = 0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic check;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

[design/dtcpq_ctrl.sv]
module dtcpq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dtcpq_pkg::t_dp_status i_status,
    output dtcpq_pkg::t_dp_cmd    o_cmd
);
    import dtcpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    in_ready     = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        accept = i_in_valid && in_ready;
        if (accept) begin
            o_cmd.load_item = 1'b1;
            n_state = S_CHECK;
        end
        o_in_stall = !in_ready;
    end

endmodule

[design/dtcpq_dpath.sv]
module dtcpq_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtcpq_pkg::t_dp_cmd                  i_cmd,
    output dtcpq_pkg::t_dp_status               o_status,
    input  logic [dtcpq_pkg::CMD_BITS-1:0]      i_cmd_in,
    input  logic [dtcpq_pkg::ID_BITS-1:0]       i_patient_id,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dtcpq_pkg::STATUS_BITS-1:0]   o_status_out,
    output logic [dtcpq_pkg::ID_BITS-1:0]       o_served_id
);
    import dtcpq_pkg::*;

    logic [CMD_BITS-1:0] r_cmd;
    logic [ID_BITS-1:0]  r_id;

    t_entry r_n_mem [QUEUE_DEPTH];
    t_entry r_u_mem [QUEUE_DEPTH];
    t_entry r_n_head;
    t_entry r_u_head;

    logic [PTR_BITS-1:0] r_n_rd, r_n_wr, r_u_rd, r_u_wr;
    logic [CNT_BITS-1:0] r_n_cnt, r_u_cnt;

    logic [ID_BITS-1:0]   r_set_ids [SET_DEPTH];
    logic [SET_DEPTH-1:0] r_set_valid;

    logic                 r_dup;
    logic [SLOT_BITS-1:0] r_free_slot;

    logic                 dup;
    logic [SLOT_BITS-1:0] free_slot;

    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [ID_BITS-1:0]     r_out_id;

    logic                   n_pop_u, n_pop_n, n_push_u, n_push_n;
    logic [STATUS_BITS-1:0] n_status;
    logic [ID_BITS-1:0]     n_served;
    logic [SLOT_BITS-1:0]   n_clear_slot;

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd <= i_cmd_in;
            r_id  <= i_patient_id;
        end
    end

    always_comb begin
        dup       = 1'b0;
        free_slot = '0;
        for (int i = SET_DEPTH - 1; i >= 0; i--) begin
            if (r_set_valid[i] && (r_set_ids[i] == r_id)) begin
                dup = 1'b1;
            end
            if (!r_set_valid[i]) begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_dup       <= dup;
            r_free_slot <= free_slot;
            r_n_head    <= r_n_mem[r_n_rd];
            r_u_head    <= r_u_mem[r_u_rd];
        end
    end

    always_comb begin
        n_pop_u      = 1'b0;
        n_pop_n      = 1'b0;
        n_push_u     = 1'b0;
        n_push_n     = 1'b0;
        n_served     = '0;
        n_clear_slot = r_u_head.slot;
        if (r_cmd[CMD_SERVE_BIT]) begin
            if (r_u_cnt != '0) begin
                n_status = ST_SERVED_URGENT;
                n_served = r_u_head.id;
                n_pop_u  = 1'b1;
            end else if (r_n_cnt != '0) begin
                n_status     = ST_SERVED_NORMAL;
                n_served     = r_n_head.id;
                n_clear_slot = r_n_head.slot;
                n_pop_n      = 1'b1;
            end else begin
                n_status = ST_EMPTY;
            end
        end else if (r_dup) begin
            n_status = ST_DUPLICATE;
        end else if (r_cmd[CMD_URGENT_BIT]) begin
            if (r_u_cnt == CNT_BITS'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_ACCEPTED;
                n_push_u = 1'b1;
            end
        end else begin
            if (r_n_cnt == CNT_BITS'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_ACCEPTED;
                n_push_n = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_push_n) begin
            r_n_mem[r_n_wr] <= '{slot: r_free_slot, id: r_id};
        end
        if (i_cmd.commit && n_push_u) begin
            r_u_mem[r_u_wr] <= '{slot: r_free_slot, id: r_id};
        end
        if (i_cmd.commit && (n_push_n || n_push_u)) begin
            r_set_ids[r_free_slot] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_rd      <= '0;
            r_n_wr      <= '0;
            r_n_cnt     <= '0;
            r_u_rd      <= '0;
            r_u_wr      <= '0;
            r_u_cnt     <= '0;
            r_set_valid <= '0;
        end else if (i_cmd.commit) begin
            if (n_push_n) begin
                r_n_wr  <= next_ptr(r_n_wr);
                r_n_cnt <= r_n_cnt + 1'b1;
                r_set_valid[r_free_slot] <= 1'b1;
            end
            if (n_push_u) begin
                r_u_wr  <= next_ptr(r_u_wr);
                r_u_cnt <= r_u_cnt + 1'b1;
                r_set_valid[r_free_slot] <= 1'b1;
            end
            if (n_pop_n) begin
                r_n_rd  <= next_ptr(r_n_rd);
                r_n_cnt <= r_n_cnt - 1'b1;
                r_set_valid[n_clear_slot] <= 1'b0;
            end
            if (n_pop_u) begin
                r_u_rd  <= next_ptr(r_u_rd);
                r_u_cnt <= r_u_cnt - 1'b1;
                r_set_valid[n_clear_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_id     <= n_served;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status_out = r_out_status;
    assign o_served_id  = r_out_id;

endmodule

[design/dedup_two_class_priority_queue.sv]
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_cmd, i_patient_id
// output    o_out_valid   i_out_stall   o_status, o_served_id
//
// Each item passes a set compare and queue head read, then the
// queue and set update, which loads the output register.
// A new item can be taken in the update cycle of the last one, but not in its check cycle.
// Reset is synchronous and empties both queues and the waiting set.
// An update waits while a stalled result holds the output register.
module dedup_two_class_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dtcpq_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic [dtcpq_pkg::ID_BITS-1:0]       i_patient_id,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dtcpq_pkg::STATUS_BITS-1:0]   o_status,
    output logic [dtcpq_pkg::ID_BITS-1:0]       o_served_id
);
    import dtcpq_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    dtcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    dtcpq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_cmd_in     (i_cmd),
        .i_patient_id (i_patient_id),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status_out (o_status),
        .o_served_id  (o_served_id)
    );

endmodule

[design/dtcpq_checker.sv]
module dtcpq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [dtcpq_pkg::CMD_BITS-1:0]      i_cmd,
    input logic [dtcpq_pkg::ID_BITS-1:0]       i_patient_id,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [dtcpq_pkg::STATUS_BITS-1:0]   o_status,
    input logic [dtcpq_pkg::ID_BITS-1:0]       o_served_id
);
    import dtcpq_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_served_id))
        else $error("stalled output item changed");

    a_id_only_on_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_SERVED_URGENT) && (o_status != ST_SERVED_NORMAL)
            |-> o_served_id == '0)
        else $error("identifier shown on a result that serves nothing");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_FULL)
        else $error("status code out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item taken while the previous item is in the check cycle");

endmodule

bind dedup_two_class_priority_queue dtcpq_checker u_dtcpq_checker (.*);
